// ----- design/assert_macros.svh -----
// Assertion helpers shared by the design files.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- design/lcam_pkg.sv -----
// Shared types and constants for the Laguerre cell argmax map.
// No dependencies.
`timescale 1ns / 1ps
package lcam_pkg;
	localparam int DEF_TARGET_DEPTH = 1024;
	localparam int DEF_DIM          = 3;

	localparam logic [31:0] LN2_Q32 = 32'd2977044472;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [1:0] REG_COUNT  = 2'd0;
	localparam logic [1:0] REG_EPS    = 2'd1;
	localparam logic [1:0] REG_RADIUS = 2'd2;

	localparam logic [10:0] RST_COUNT  = 11'd1;
	localparam logic [31:0] RST_EPS    = 32'd65536;
	localparam logic [31:0] RST_RADIUS = 32'd0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LN_RUN,
		ST_LN_FIN,
		ST_SCAN,
		ST_DRAIN,
		ST_PICK,
		ST_EMIT
	} lcam_state_t;

	typedef struct packed {
		logic [31:0] c0;
		logic [31:0] c1;
		logic [31:0] c2;
		logic [31:0] pot;
		logic [47:0] logd;
		logic        dz;
	} lcam_entry_t;
endpackage

// ----- design/laguerre_cell_argmax_map_top.sv -----
// Laguerre cell argmax map: target table in one synchronous RAM, scanned per query.
// Depends on lcam_pkg and assert_macros.svh.
// Load: accept, 16 squaring steps, then scale to ln and write; a new beat is taken only in idle.
// Query: the clamped target_count entries are scanned, then the pick is emitted once the output
// is free; a new beat is taken only back in idle. One RAM read per cycle feeds a 5-stage pipe.
// Reset (arst_n low) clears control and config registers; table contents stay undefined.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module laguerre_cell_argmax_map_top
	import lcam_pkg::*;
#(
	parameter int TARGET_DEPTH = DEF_TARGET_DEPTH,
	parameter int DIM          = DEF_DIM
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               opcode,
	input  logic [9:0]         target_index,
	input  logic signed [31:0] point_coord_0,
	input  logic signed [31:0] point_coord_1,
	input  logic signed [31:0] point_coord_2,
	input  logic signed [31:0] point_potential,
	input  logic [31:0]        point_density,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [9:0]         mapped_index,
	output logic signed [31:0] mapped_coord_0,
	output logic signed [31:0] mapped_coord_1,
	output logic signed [31:0] mapped_coord_2,
	output logic [31:0]        carried_density
);
	localparam int AW = $clog2(TARGET_DEPTH);
	localparam int IW = (AW > 10) ? AW : 10;
	localparam logic [31:0] DEPTH32 = 32'(TARGET_DEPTH);

	// configuration
	logic [10:0] cnt_q;
	logic [31:0] eps_q;
	logic [31:0] rad_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= RST_COUNT;
			eps_q <= RST_EPS;
			rad_q <= RST_RADIUS;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_COUNT:  cnt_q <= pwdata[10:0];
				REG_EPS:    eps_q <= pwdata;
				REG_RADIUS: rad_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_COUNT:  prdata = {21'd0, cnt_q};
			REG_EPS:    prdata = eps_q;
			REG_RADIUS: prdata = rad_q;
			default:    prdata = 32'd0;
		endcase
	end

	// control
	lcam_state_t state_q, state_d;
	logic          in_acc;
	logic          slot_ok;
	logic [IW-1:0] tidx_w;
	logic [3:0]    step_q;
	logic [AW-1:0] j_q, last_q;
	logic          v_s1, v_s2, v_s3, v_s4, v_s5;
	logic          pipe_busy;
	logic          out_valid_q;
	logic          out_free;
	logic          trunc;
	logic [AW-1:0] pick_idx;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          mem_we;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid & in_ready;
	assign tidx_w    = IW'(target_index);
	assign slot_ok   = ({22'd0, target_index} < DEPTH32);
	assign pipe_busy = v_s1 | v_s2 | v_s3 | v_s4 | v_s5;
	assign out_free  = !out_valid_q || out_ready;
	assign trunc     = (rad_q != 32'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = j_q;
		mem_we  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (opcode == OP_QUERY) state_d = ST_SCAN;
					else if (slot_ok)       state_d = ST_LN_RUN;
				end
			end
			ST_LN_RUN: begin
				if (step_q == 4'd15) state_d = ST_LN_FIN;
			end
			ST_LN_FIN: begin
				mem_we  = 1'b1;
				state_d = ST_IDLE;
			end
			ST_SCAN: begin
				rd_en = 1'b1;
				if (j_q == last_q) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!pipe_busy) state_d = ST_PICK;
			end
			ST_PICK: begin
				rd_addr = pick_idx;
				if (out_free) begin
					rd_en   = 1'b1;
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// query operands and count clamp
	logic [31:0] n32, last32;
	always_comb begin
		n32 = {21'd0, cnt_q};
		if (n32 == 32'd0)     n32 = 32'd1;
		if (n32 > DEPTH32)    n32 = DEPTH32;
		last32 = n32 - 32'd1;
	end

	logic [31:0] q_c0_q, q_c1_q, q_c2_q, q_dens_q;
	logic [47:0] rr_q;
	logic [63:0] rr_prod;
	assign rr_prod = {32'd0, rad_q} * {32'd0, rad_q};

	always_ff @(posedge clk) begin
		if (in_acc && opcode == OP_QUERY) begin
			q_c0_q   <= point_coord_0;
			q_c1_q   <= point_coord_1;
			q_c2_q   <= point_coord_2;
			q_dens_q <= point_density;
			rr_q     <= rr_prod[63:16];
			last_q   <= last32[AW-1:0];
		end
	end

	// log unit: one squaring step per cycle
	logic [31:0] ld_c0_q, ld_c1_q, ld_c2_q, ld_pot_q, ld_dens_q;
	logic [AW-1:0] wr_addr_q;
	logic [4:0]  msb;
	logic [4:0]  p_q;
	logic [31:0] x_q;
	logic [15:0] frac_q;
	logic [63:0] x_sq;
	logic [32:0] x_nx;

	always_comb begin
		msb = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (point_density[i]) msb = 5'(i);
		end
	end

	assign x_sq = {32'd0, x_q} * {32'd0, x_q};
	assign x_nx = x_sq[63:31];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 4'd0;
		end else if (state_q == ST_LN_RUN) begin
			step_q <= step_q + 4'd1;
		end else begin
			step_q <= 4'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && opcode == OP_LOAD) begin
			ld_c0_q   <= point_coord_0;
			ld_c1_q   <= point_coord_1;
			ld_c2_q   <= (DIM > 2) ? point_coord_2 : 32'd0;
			ld_pot_q  <= point_potential;
			ld_dens_q <= point_density;
			wr_addr_q <= tidx_w[AW-1:0];
			p_q       <= msb;
			x_q       <= point_density << (5'd31 - msb);
			frac_q    <= 16'd0;
		end else if (state_q == ST_LN_RUN) begin
			frac_q <= {frac_q[14:0], x_nx[32]};
			x_q    <= x_nx[32] ? x_nx[32:1] : x_nx[31:0];
		end
	end

	// scale log2 to ln and build the table entry
	logic signed [5:0]  l2_int;
	logic signed [21:0] l2;
	logic [21:0]        l2_mag;
	logic [63:0]        ln_prod;
	logic [31:0]        ln_mag;
	logic [47:0]        ln_val;
	lcam_entry_t        wentry;

	always_comb begin
		l2_int  = $signed({1'b0, p_q}) - 6'sd16;
		l2      = {l2_int, frac_q};
		l2_mag  = l2[21] ? 22'(-l2) : 22'(l2);
		ln_prod = {42'd0, l2_mag} * {32'd0, LN2_Q32} + 64'h8000_0000;
		ln_mag  = ln_prod[63:32];
		ln_val  = l2[21] ? -{16'd0, ln_mag} : {16'd0, ln_mag};
		wentry.c0   = ld_c0_q;
		wentry.c1   = ld_c1_q;
		wentry.c2   = ld_c2_q;
		wentry.pot  = ld_pot_q;
		wentry.dz   = (ld_dens_q == 32'd0);
		wentry.logd = (ld_dens_q == 32'd0) ? 48'd0 : ln_val;
	end

	// target table
	lcam_entry_t mem [TARGET_DEPTH];
	lcam_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_addr_q] <= wentry;
		if (rd_en)  rdata_q <= mem[rd_addr];
	end

	// scan address and valid pipeline
	logic [AW-1:0] idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q  <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (in_acc) j_q <= '0;
			else if (state_q == ST_SCAN) j_q <= j_q + 1'b1;
			v_s1 <= (state_q == ST_SCAN);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// s1 -> s2: coordinate differences
	logic [32:0] d0, d1, d2;
	logic [31:0] m0_s2, m1_s2, m2_s2, pot_s2, pot_s3, pot_s4;
	logic [47:0] ln_s2;
	logic        dz_s2, dz_s3, dz_s4, dz_s5;
	assign d0 = {q_c0_q[31], q_c0_q} - {rdata_q.c0[31], rdata_q.c0};
	assign d1 = {q_c1_q[31], q_c1_q} - {rdata_q.c1[31], rdata_q.c1};
	assign d2 = {q_c2_q[31], q_c2_q} - {rdata_q.c2[31], rdata_q.c2};

	// s2 -> s3: squares and log weighting
	logic [63:0] sq0, sq1, sq2, lt_prod;
	logic [47:0] ln_abs;
	logic [47:0] t0_s3, t1_s3, t2_s3, ltm_s3;
	logic        ltn_s3;
	assign sq0     = {32'd0, m0_s2} * {32'd0, m0_s2};
	assign sq1     = {32'd0, m1_s2} * {32'd0, m1_s2};
	assign sq2     = {32'd0, m2_s2} * {32'd0, m2_s2};
	assign ln_abs  = ln_s2[47] ? -ln_s2 : ln_s2;
	assign lt_prod = {32'd0, ln_abs[31:0]} * {32'd0, eps_q};

	// s3 -> s4: distance sum, signed log term
	logic [49:0]        s_s4;
	logic signed [63:0] lt_s4;

	// s4 -> s5: score and radius test
	logic signed [63:0] sc_s5;
	logic               in_s5;

	always_ff @(posedge clk) begin
		m0_s2  <= d0[32] ? 32'(-d0) : d0[31:0];
		m1_s2  <= d1[32] ? 32'(-d1) : d1[31:0];
		m2_s2  <= (DIM > 2) ? (d2[32] ? 32'(-d2) : d2[31:0]) : 32'd0;
		pot_s2 <= rdata_q.pot;
		ln_s2  <= rdata_q.logd;
		dz_s2  <= rdata_q.dz;
		idx_s2 <= idx_s1;

		t0_s3  <= sq0[63:16];
		t1_s3  <= sq1[63:16];
		t2_s3  <= sq2[63:16];
		ltm_s3 <= lt_prod[63:16];
		ltn_s3 <= ln_s2[47];
		pot_s3 <= pot_s2;
		dz_s3  <= dz_s2;
		idx_s3 <= idx_s2;

		s_s4   <= {2'd0, t0_s3} + {2'd0, t1_s3} + {2'd0, t2_s3};
		lt_s4  <= ltn_s3 ? -$signed({16'd0, ltm_s3}) : $signed({16'd0, ltm_s3});
		pot_s4 <= pot_s3;
		dz_s4  <= dz_s3;
		idx_s4 <= idx_s3;

		sc_s5  <= $signed({{32{pot_s4[31]}}, pot_s4}) + lt_s4
			- $signed({15'd0, s_s4[49:1]});
		in_s5  <= !trunc || (s_s4 < {2'd0, rr_q});
		dz_s5  <= dz_s4;
		idx_s5 <= idx_s4;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN) idx_s1 <= j_q;
	end

	// running nearest and best
	logic [49:0]        near_s_q;
	logic [AW-1:0]      near_idx_q, best_idx_q, fin_idx_q;
	logic               near_dz_q;
	logic signed [63:0] best_q;
	logic               have_q, inside_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q     <= 1'b0;
			inside_q   <= 1'b0;
			best_idx_q <= '0;
			near_idx_q <= '0;
			near_dz_q  <= 1'b0;
		end else if (in_acc) begin
			have_q     <= 1'b0;
			inside_q   <= 1'b0;
			best_idx_q <= '0;
		end else begin
			if (v_s4 && (idx_s4 == '0 || s_s4 < near_s_q)) begin
				near_idx_q <= idx_s4;
				near_dz_q  <= dz_s4;
			end
			if (v_s4 && (!trunc || s_s4 < {2'd0, rr_q})) inside_q <= 1'b1;
			if (v_s5 && in_s5 && !dz_s5 && (!have_q || sc_s5 > best_q)) begin
				have_q     <= 1'b1;
				best_idx_q <= idx_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s4 && (idx_s4 == '0 || s_s4 < near_s_q)) near_s_q <= s_s4;
		if (v_s5 && in_s5 && !dz_s5 && (!have_q || sc_s5 > best_q)) best_q <= sc_s5;
	end

	// fall back to the nearest target when nothing lies inside the radius, unless it has zero density
	assign pick_idx = (trunc && !inside_q && !near_dz_q) ? near_idx_q : best_idx_q;

	// output register
	logic [IW-1:0] fin_w;
	logic [31:0]   o_c0_q, o_c1_q, o_c2_q, o_dens_q;
	assign fin_w = IW'(fin_idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)                   out_valid_q <= 1'b0;
		else if (state_q == ST_EMIT)   out_valid_q <= 1'b1;
		else if (out_ready)            out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PICK && out_free) fin_idx_q <= pick_idx;
		if (state_q == ST_EMIT) begin
			o_c0_q   <= rdata_q.c0;
			o_c1_q   <= rdata_q.c1;
			o_c2_q   <= rdata_q.c2;
			o_dens_q <= q_dens_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign mapped_index    = fin_w[9:0];
	assign mapped_coord_0  = o_c0_q;
	assign mapped_coord_1  = o_c1_q;
	assign mapped_coord_2  = o_c2_q;
	assign carried_density = o_dens_q;

	`ASSERT_IMPL(a_emit_free, clk, arst_n, state_q == ST_EMIT, !out_valid_q, "output busy at emit")
	`ASSERT_IMPL(a_pipe_scan, clk, arst_n, v_s1, state_q == ST_SCAN || state_q == ST_DRAIN, "stray scan beat")
	`ASSERT_IMPL(a_pick_drained, clk, arst_n, state_q == ST_PICK, !pipe_busy, "pick before drain")
	`ASSERT_IMPL(a_have_inside, clk, arst_n, have_q, inside_q, "scored target outside radius")
	`ASSERT_NEXT(a_no_write_scan, clk, arst_n, state_q == ST_SCAN, !mem_we, "table write during scan")
endmodule
